// ===== sv/wsfe_pkg.sv =====
// shared types, constants and helpers for the websocket frame encoder
package wsfe_pkg;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  localparam int IDX_W   = 4;
  localparam int HDR_MAX = 14;
  localparam int HDR_SLOTS = 2 ** IDX_W;

  localparam int IN_LEN_W = 32;
  localparam int EXT_LEN_W = 64;

  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;
  localparam logic [7:0] MASK_BIT   = 8'h80;
  localparam int KEY_BYTES = 4;

  // header byte positions of the key per length form
  localparam int KEY_OFF7  = 2;
  localparam int KEY_OFF16 = 4;
  localparam int KEY_OFF64 = 10;

  typedef logic [7:0] byte_t;
  typedef byte_t hdr_buf_t [HDR_SLOTS];

  // control from the sequencer to the frame state
  typedef struct packed {
    logic start;
    logic step;
  } wsfe_ctl_t;

  // frame state seen by the sequencer
  typedef struct packed {
    logic empty;
    logic last_byte;
  } wsfe_stat_t;

  function automatic byte_t key_byte(input logic [31:0] key, input logic [1:0] phase);
    byte_t b;
    unique case (phase)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== sv/wsfe_hdr_gen.sv =====
// header byte generator: picks one header byte of a start request by index
module wsfe_hdr_gen #(
  parameter int LEN_W = 32
) (
  input  logic [3:0]                  opcode,
  input  logic                        fin,
  input  logic                        mask_on,
  input  logic [31:0]                 mask_key,
  input  logic [LEN_W-1:0]            len,
  input  logic [wsfe_pkg::IDX_W-1:0]  idx,
  output logic [7:0]                  hdr_byte,
  output logic [wsfe_pkg::IDX_W-1:0]  last_idx,
  output logic                        len_zero
);

  wsfe_pkg::hdr_buf_t hdr;
  logic [wsfe_pkg::EXT_LEN_W-1:0] len_ext;
  logic [7:0] mbit;
  logic [wsfe_pkg::IDX_W-1:0] base_last;

  always_comb begin
    len_ext = wsfe_pkg::EXT_LEN_W'(len);
    mbit    = mask_on ? wsfe_pkg::MASK_BIT : 8'h00;
    for (int i = 0; i < wsfe_pkg::HDR_SLOTS; i++) begin
      hdr[i] = 8'h00;
    end
    hdr[0] = {fin, 3'b000, opcode};
    priority if (len_ext < wsfe_pkg::EXT_LEN_W'(wsfe_pkg::LEN_CODE16)) begin
      hdr[1] = mbit | {1'b0, len_ext[6:0]};
      for (int k = 0; k < wsfe_pkg::KEY_BYTES; k++) begin
        hdr[wsfe_pkg::KEY_OFF7 + k] = wsfe_pkg::key_byte(mask_key, 2'(k));
      end
      base_last = wsfe_pkg::IDX_W'(wsfe_pkg::KEY_OFF7 - 1);
    end else if (len_ext[wsfe_pkg::EXT_LEN_W-1:16] == '0) begin
      hdr[1] = mbit | {1'b0, wsfe_pkg::LEN_CODE16};
      hdr[2] = len_ext[15:8];
      hdr[3] = len_ext[7:0];
      for (int k = 0; k < wsfe_pkg::KEY_BYTES; k++) begin
        hdr[wsfe_pkg::KEY_OFF16 + k] = wsfe_pkg::key_byte(mask_key, 2'(k));
      end
      base_last = wsfe_pkg::IDX_W'(wsfe_pkg::KEY_OFF16 - 1);
    end else begin
      hdr[1] = mbit | {1'b0, wsfe_pkg::LEN_CODE64};
      // 64-bit length, big endian
      for (int j = 0; j < 8; j++) begin
        hdr[2 + j] = len_ext[8*(7-j) +: 8];
      end
      for (int k = 0; k < wsfe_pkg::KEY_BYTES; k++) begin
        hdr[wsfe_pkg::KEY_OFF64 + k] = wsfe_pkg::key_byte(mask_key, 2'(k));
      end
      base_last = wsfe_pkg::IDX_W'(wsfe_pkg::KEY_OFF64 - 1);
    end
    last_idx = mask_on ? base_last + wsfe_pkg::IDX_W'(wsfe_pkg::KEY_BYTES) : base_last;
    hdr_byte = hdr[idx];
    len_zero = (len == '0);
  end

endmodule

// ===== sv/wsfe_frame_state.sv =====
// per-frame state: key, mask flag, key phase, bytes left; masks payload bytes
module wsfe_frame_state #(
  parameter int LEN_W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wsfe_pkg::wsfe_ctl_t  ctl,
  input  logic                 mask_on,
  input  logic [31:0]          mask_key,
  input  logic [LEN_W-1:0]     len,
  input  logic [7:0]           data_byte,
  output logic [7:0]           masked_byte,
  output wsfe_pkg::wsfe_stat_t stat
);

  logic [31:0]      key_store;
  logic             masking_active;
  logic [1:0]       key_phase;
  logic [LEN_W-1:0] bytes_remaining;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_store       <= '0;
      masking_active  <= 1'b0;
      key_phase       <= '0;
      bytes_remaining <= '0;
    end else if (ctl.start) begin
      key_store       <= mask_key;
      masking_active  <= mask_on;
      key_phase       <= '0;
      bytes_remaining <= len;
    end else if (ctl.step) begin
      key_phase       <= key_phase + 2'd1;
      bytes_remaining <= bytes_remaining - LEN_W'(1);
    end
  end

  always_comb begin
    masked_byte    = masking_active ? (data_byte ^ wsfe_pkg::key_byte(key_store, key_phase))
                                    : data_byte;
    stat.empty     = (bytes_remaining == '0);
    stat.last_byte = (bytes_remaining == LEN_W'(1));
  end

endmodule

// ===== sv/websocket_frame_encoder_top.sv =====
// a request is held in the request register, its bytes then in the result register
// throughput: payload requests one per cycle unless results stall; a start request
//   holds input for 2, 4 or 10 header bytes by length form, plus 4 with masking (up to 14)
// the header sequencer walks one byte index per unstalled cycle over one request register
// reset: synchronous, clears request and result valid, header index and frame state
// payload requests arriving with no bytes left are dropped
module websocket_frame_encoder_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        mode,
  input  logic [3:0]  opcode,
  input  logic        fin,
  input  logic        mask_on,
  input  logic [31:0] mask_key,
  input  logic [31:0] payload_length,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        is_header,
  output logic        last_of_run,
  output logic        frame_done
);

  // only the low bits of the length matter, and never more than the port carries
  localparam int LEN_W = (LENGTH_BITS < wsfe_pkg::IN_LEN_W) ? LENGTH_BITS
                                                            : wsfe_pkg::IN_LEN_W;

  // request register
  logic             held;
  logic             held_next;
  logic             held_mode;
  logic [3:0]       held_opcode;
  logic             held_fin;
  logic             held_mask_on;
  logic [31:0]      held_key;
  logic [LEN_W-1:0] held_len;
  logic [7:0]       held_data;

  // header byte index within the current start request
  logic [wsfe_pkg::IDX_W-1:0] idx;
  logic [wsfe_pkg::IDX_W-1:0] idx_next;

  logic       accept;
  logic       out_free;
  logic       produce;
  logic       consume;
  logic       is_start;
  logic       hdr_last;

  logic [7:0]                 hdr_byte;
  logic [wsfe_pkg::IDX_W-1:0] last_idx;
  logic                       len_zero;
  logic [7:0]                 masked_byte;
  wsfe_pkg::wsfe_ctl_t        ctl;
  wsfe_pkg::wsfe_stat_t       stat;

  logic result_valid_next;

  wsfe_hdr_gen #(.LEN_W(LEN_W)) u_hdr (
    .opcode   (held_opcode),
    .fin      (held_fin),
    .mask_on  (held_mask_on),
    .mask_key (held_key),
    .len      (held_len),
    .idx      (idx),
    .hdr_byte (hdr_byte),
    .last_idx (last_idx),
    .len_zero (len_zero)
  );

  wsfe_frame_state #(.LEN_W(LEN_W)) u_state (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .mask_on     (held_mask_on),
    .mask_key    (held_key),
    .len         (held_len),
    .data_byte   (held_data),
    .masked_byte (masked_byte),
    .stat        (stat)
  );

  always_comb begin
    is_start = (held_mode == wsfe_pkg::MODE_START);
    hdr_last = (idx == last_idx);
    // result register can take a byte when empty or being drained
    out_free = !result_valid || !result_stall;
    produce  = held && out_free && (is_start || !stat.empty);
    // request retires on its last header byte, its payload byte, or when dropped
    priority if (!held) begin
      consume = 1'b0;
    end else if (is_start) begin
      consume = out_free && hdr_last;
    end else begin
      consume = stat.empty || out_free;
    end
    item_stall = held && !consume;
    accept     = item_valid && !item_stall;
    held_next  = accept || (held && !consume);

    // frame state loads on the start request's last header byte, steps per payload byte
    ctl.start = produce && is_start && hdr_last;
    ctl.step  = produce && !is_start;

    priority if (produce && is_start) begin
      idx_next = hdr_last ? '0 : idx + wsfe_pkg::IDX_W'(1);
    end else begin
      idx_next = idx;
    end

    result_valid_next = produce || (result_valid && result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      held         <= held_next;
      idx          <= idx_next;
      result_valid <= result_valid_next;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      held_mode    <= mode;
      held_opcode  <= opcode;
      held_fin     <= fin;
      held_mask_on <= mask_on;
      held_key     <= mask_key;
      held_len     <= payload_length[LEN_W-1:0];
      held_data    <= data_byte;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (produce) begin
      if (is_start) begin
        out_byte    <= hdr_byte;
        is_header   <= 1'b1;
        last_of_run <= hdr_last;
        frame_done  <= hdr_last && len_zero;
      end else begin
        out_byte    <= masked_byte;
        is_header   <= 1'b0;
        last_of_run <= 1'b1;
        frame_done  <= stat.last_byte;
      end
    end
  end

endmodule

// ===== sv/wsfe_checker.sv =====
// port-level checker for the websocket frame encoder, bound to the top level
module wsfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] out_byte,
  input logic       is_header,
  input logic       last_of_run,
  input logic       frame_done
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its byte
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(out_byte))
    else $error("result byte changed while stalled");

  // frame end only on the closing byte of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  // each payload request yields a single byte
  a_payload_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_header |-> last_of_run)
    else $error("payload byte not closing its run");

endmodule

bind websocket_frame_encoder_top wsfe_checker u_wsfe_checker (.*);

// ===== tb/wsfe_frame_checker.sv =====
// frame checker: predicts the encoder's wire bytes per request and compares accepted results
module wsfe_frame_checker #(
  parameter int LEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        mode,
  input  logic [3:0]  opcode,
  input  logic        fin,
  input  logic        mask_on,
  input  logic [31:0] mask_key,
  input  logic [31:0] payload_length,
  input  logic [7:0]  data_byte,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [7:0]  out_byte,
  input  logic        is_header,
  input  logic        last_of_run,
  input  logic        frame_done,
  output int          fails,
  output int          waiting
);

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
    logic       done;
  } wire_byte_t;

  // wire bytes still owed by the encoder, oldest first
  wire_byte_t wire_q[$];
  int         miss_total = 0;

  // frame state of the prediction
  logic [31:0] frame_key;
  logic        frame_masked;
  logic [1:0]  frame_phase;
  logic [63:0] frame_left;

  function automatic logic [7:0] key_lane(input logic [31:0] key, input logic [1:0] lane);
    logic [31:0] s;
    s = key >> (8 * (3 - int'(lane)));
    return s[7:0];
  endfunction

  function automatic void predict_wire_bytes();
    logic [7:0]  hdr [wsfe_pkg::HDR_MAX];
    int          n;
    logic [63:0] len;
    logic [7:0]  b;
    wire_byte_t  w;
    if (mode == wsfe_pkg::MODE_START) begin
      n   = 0;
      len = {32'b0, payload_length};
      if (LEN_BITS < 64) len &= (64'd1 << LEN_BITS) - 64'd1;
      hdr[n] = {fin, 3'b000, opcode};
      n++;
      if (len < 64'd126) begin
        hdr[n] = {mask_on, len[6:0]};
        n++;
      end else if (len <= 64'hFFFF) begin
        hdr[n] = {mask_on, wsfe_pkg::LEN_CODE16};
        n++;
        hdr[n] = len[15:8];
        n++;
        hdr[n] = len[7:0];
        n++;
      end else begin
        hdr[n] = {mask_on, wsfe_pkg::LEN_CODE64};
        n++;
        for (int i = 7; i >= 0; i--) begin
          hdr[n] = len[8*i +: 8];
          n++;
        end
      end
      if (mask_on) begin
        for (int i = 0; i < wsfe_pkg::KEY_BYTES; i++) begin
          hdr[n] = key_lane(mask_key, 2'(i));
          n++;
        end
      end
      frame_key    = mask_key;
      frame_masked = mask_on;
      frame_phase  = 2'd0;
      frame_left   = len;
      for (int i = 0; i < n; i++) begin
        w.data = hdr[i];
        w.hdr  = 1'b1;
        w.last = (i == n - 1);
        w.done = w.last && (len == 64'd0);
        wire_q.push_back(w);
      end
    end else if (frame_left != 64'd0) begin
      b = data_byte;
      if (frame_masked) b ^= key_lane(frame_key, frame_phase);
      frame_phase++;
      frame_left--;
      w.data = b;
      w.hdr  = 1'b0;
      w.last = 1'b1;
      w.done = (frame_left == 64'd0);
      wire_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    wire_byte_t got;
    wire_byte_t want;
    if (rst) begin
      frame_key    = '0;
      frame_masked = 1'b0;
      frame_phase  = 2'd0;
      frame_left   = '0;
      wire_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = {out_byte, is_header, last_of_run, frame_done};
        if (wire_q.size() == 0) begin
          if (miss_total < 10)
            $display("unexpected result: byte %02h hdr %0b last %0b done %0b",
                     got.data, got.hdr, got.last, got.done);
          miss_total++;
        end else begin
          want = wire_q.pop_front();
          if (got != want) begin
            if (miss_total < 10)
              $display({"mismatch: expected byte %02h hdr %0b last %0b done %0b, ",
                        "got byte %02h hdr %0b last %0b done %0b"},
                       want.data, want.hdr, want.last, want.done,
                       got.data, got.hdr, got.last, got.done);
            miss_total++;
          end
        end
      end
      if (item_valid && !item_stall) predict_wire_bytes();
    end
    fails   <= miss_total;
    waiting <= wire_q.size();
  end

endmodule

// ===== tb/websocket_frame_encoder_top_tb.sv =====
// testbench top: drives frame and payload requests into the encoder and gives the verdict
module websocket_frame_encoder_top_tb;

  localparam int LEN_BITS        = 32;
  localparam int RANDOM_REQUESTS = 200;
  // settle margin for dropped payload requests still in flight
  localparam int SETTLE_CYCLES   = 10;
  localparam int DRAIN_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        mode = wsfe_pkg::MODE_DATA;
  logic [3:0]  opcode = '0;
  logic        fin = 1'b0;
  logic        mask_on = 1'b0;
  logic [31:0] mask_key = '0;
  logic [31:0] payload_length = '0;
  logic [7:0]  data_byte = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        is_header;
  logic        last_of_run;
  logic        frame_done;

  int mismatches;
  int bytes_due;

  // sender bookkeeping: requests accepted so far
  int          counted = 0;
  // no gaps for the current sequence
  logic        gapless = 1'b0;
  // random phase has begun, used to place the long receiver hold-off
  logic        in_random = 1'b0;

  // 20 unit period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  websocket_frame_encoder_top #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .opcode(opcode),
    .fin(fin),
    .mask_on(mask_on),
    .mask_key(mask_key),
    .payload_length(payload_length),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte(out_byte),
    .is_header(is_header),
    .last_of_run(last_of_run),
    .frame_done(frame_done)
  );

  wsfe_frame_checker #(.LEN_BITS(LEN_BITS)) frame_check (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .opcode(opcode),
    .fin(fin),
    .mask_on(mask_on),
    .mask_key(mask_key),
    .payload_length(payload_length),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte(out_byte),
    .is_header(is_header),
    .last_of_run(last_of_run),
    .frame_done(frame_done),
    .fails(mismatches),
    .waiting(bytes_due)
  );

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request: optional gap, then hold valid and payload until accepted
  task automatic offer_request(input logic m, input logic [3:0] op, input logic f,
                               input logic mk, input logic [31:0] key,
                               input logic [31:0] len, input logic [7:0] data);
    int gap;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid     = 1'b1;
    mode           = m;
    opcode         = op;
    fin            = f;
    mask_on        = mk;
    mask_key       = key;
    payload_length = len;
    data_byte      = data;
    // accepted at the first rising edge with stall low
    @(posedge clk);
    while (item_stall) @(posedge clk);
    counted++;
    @(negedge clk);
  endtask

  task automatic start_frame(input logic [3:0] op, input logic f, input logic mk,
                             input logic [31:0] key, input logic [31:0] len);
    offer_request(wsfe_pkg::MODE_START, op, f, mk, key, len, 8'($urandom));
  endtask

  task automatic payload(input logic [7:0] data);
    offer_request(wsfe_pkg::MODE_DATA, 4'($urandom), 1'($urandom), 1'($urandom),
                  $urandom, $urandom, data);
  endtask

  // receiver: open for a while, then stall for a random gap
  task automatic receiver_pattern();
    int open_len;
    int shut_len;
    open_len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
    shut_len = pick_gap();
    result_stall = 1'b0;
    repeat (open_len) @(negedge clk);
    if (shut_len > 0) begin
      result_stall = 1'b1;
      repeat (shut_len) @(negedge clk);
    end
  endtask

  // receiver process, with one long hold-off early in the random phase
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    while (!in_random) receiver_pattern();
    repeat (20) receiver_pattern();
    // sender keeps offering while results back up and the input stalls
    result_stall = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    result_stall = 1'b0;
    forever receiver_pattern();
  end

  // watchdog: fails the run if it has not finished
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int          kind;
    int          count;
    int          spin;
    logic [31:0] len;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    // payload with nothing open right after reset
    payload(8'hFF);
    // empty frames: frame done on the last header byte
    start_frame(4'h0, 1'b1, 1'b0, 32'h0000_0000, 32'd0);
    start_frame(4'hF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0);
    // payload after an empty frame is dropped
    payload(8'h00);
    // widest 7-bit length
    start_frame(4'h1, 1'b1, 1'b0, 32'h0000_0000, 32'd125);
    payload(8'h00);
    payload(8'hFF);
    // start during a frame, smallest 16-bit length, masked with an all-zero key
    start_frame(4'h2, 1'b1, 1'b1, 32'h0000_0000, 32'd126);
    payload(8'hFF);
    payload(8'h5A);
    // widest 16-bit length
    start_frame(4'h8, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd65535);
    payload(8'h00);
    // smallest 64-bit length, unmasked
    start_frame(4'h9, 1'b0, 1'b0, 32'h1234_5678, 32'd65536);
    payload(8'hC3);
    // widest length the port allows
    start_frame(4'hA, 1'b1, 1'b1, 32'h8001_7FFE, 32'hFFFF_FFFF);
    payload(8'h81);
    // complete masked frame with key lane wrap, then one byte too many
    start_frame(4'h1, 1'b1, 1'b1, 32'hA1B2_C3D4, 32'd5);
    repeat (5) payload(8'($urandom));
    payload(8'($urandom));

    // random part
    in_random = 1'b1;
    counted   = 0;
    while (counted < RANDOM_REQUESTS) begin
      kind    = $urandom_range(0, 99);
      gapless = ($urandom_range(0, 4) == 0);
      if (kind < 75) begin
        // well-formed frame, mostly short so its payload completes
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(120, 300);
          1:       len = $urandom_range(65530, 65541);
          2:       len = $urandom;
          default: len = $urandom_range(0, 16);
        endcase
        start_frame(4'($urandom), 1'($urandom), 1'($urandom), $urandom, len);
        if (len <= 16)
          count = int'(len) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        else
          count = $urandom_range(0, 6);
        repeat (count) payload(8'($urandom));
      end else if (kind < 88) begin
        // stray payload, dropped unless a long frame is still open
        repeat ($urandom_range(1, 3)) payload(8'($urandom));
      end else begin
        // broken frame: restarted before its payload completes
        len = $urandom_range(2, 12);
        start_frame(4'($urandom), 1'($urandom), 1'($urandom), $urandom, len);
        repeat ($urandom_range(0, len - 1)) payload(8'($urandom));
      end
    end
    gapless    = 1'b0;
    item_valid = 1'b0;

    // drain: wait for every predicted byte, then let the pipeline settle
    spin = 0;
    while (bytes_due != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    if (spin >= DRAIN_LIMIT) begin
      $display("CHECK FAILED");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (mismatches == 0 && bytes_due == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule
